// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the rtl folder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// clocked check, also active during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/gffra_pkg.sv -----
// ---------------------------------------------------------------------------
// gffra_pkg
// shared constants, codes and types of the grid rectangle allocator
// ---------------------------------------------------------------------------
package gffra_pkg;

    // default grid size
    localparam int DEF_GRID_COLS = 16;
    localparam int DEF_GRID_ROWS = 16;

    // field widths
    localparam int CFG_W   = 5;
    localparam int FIELD_W = 5;
    localparam int COORD_W = 4;

    // widest rectangle a request can carry
    localparam int MAX_RECT = (1 << FIELD_W) - 1;

    // internal width for sizes and row/column positions (grid up to 64 plus a rect)
    localparam int DIM_W = 8;

    // register reset values
    localparam logic [CFG_W-1:0] COLS_RST = 5'd10;
    localparam logic [CFG_W-1:0] ROWS_RST = 5'd10;

    // register indexes
    typedef enum logic {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } t_cfg_idx;

    // request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN_RD,
        S_SCAN_CNT,
        S_SCAN_FIT,
        S_SCAN_ENC,
        S_RMW_RD,
        S_RMW_WR,
        S_DONE
    } t_state;

    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ----- hw/rtl/gffra_mem.sv -----
// ---------------------------------------------------------------------------
// gffra_mem
// occupancy bitmap, one word per grid row, registered read, per-row valid flags
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gffra_mem #(
    parameter int GRID_COLS = 16,
    parameter int GRID_ROWS = 16,
    parameter int RI_W      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [RI_W-1:0]      i_rd_addr,
    output logic [GRID_COLS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [RI_W-1:0]      i_wr_addr,
    input  logic [GRID_COLS-1:0] i_wr_data
);

    logic [GRID_COLS-1:0] r_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] r_vld;
    logic [GRID_COLS-1:0] r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // a row never written since reset reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

    `ASSERT_CLK(a_no_rw_same_row, i_clk, i_rst_n, !(i_rd_en && i_wr_en && (i_rd_addr == i_wr_addr)))

endmodule

// ----- hw/rtl/gffra_fit.sv -----
// ---------------------------------------------------------------------------
// gffra_fit
// horizontal fit of a rectangle over a row of usable anchor columns
// ---------------------------------------------------------------------------
module gffra_fit
    import gffra_pkg::*;
#(
    parameter int GRID_COLS = 16,
    parameter int CI_W      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [GRID_COLS-1:0] i_ok,
    input  logic [FIELD_W-1:0]   i_width,
    output logic                 o_hit,
    output logic [CI_W-1:0]      o_col
);

    logic [GRID_COLS+MAX_RECT-1:0] w_ok_ext;
    logic [MAX_RECT-1:0]           w_span;
    logic [GRID_COLS-1:0]          w_fit;
    logic [GRID_COLS-1:0]          r_fit;

    // columns past the grid are never usable, so a window running off the edge fails
    assign w_ok_ext = {{MAX_RECT{1'b0}}, i_ok};

    always_comb begin
        for (int j = 0; j < MAX_RECT; j++) begin
            w_span[j] = (FIELD_W'(j) < i_width);
        end
    end

    always_comb begin
        for (int x = 0; x < GRID_COLS; x++) begin
            w_fit[x] = &(w_ok_ext[x +: MAX_RECT] | ~w_span);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fit <= w_fit;
        end
    end

    // lowest fitting column wins
    always_comb begin
        o_col = '0;
        for (int x = GRID_COLS - 1; x >= 0; x--) begin
            if (r_fit[x]) begin
                o_col = CI_W'(x);
            end
        end
    end

    assign o_hit = |r_fit;

endmodule

// ----- hw/rtl/grid_first_fit_rect_allocator.sv -----
// ---------------------------------------------------------------------------
// grid_first_fit_rect_allocator
// first-fit rectangle allocator over a 2d occupancy bitmap
// ---------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  request   | i_valid/o_ready, i_func, i_rect_*, i_anchor_* | in
//  result    | o_valid/i_ready, o_placed, o_found_col/row   | out
//  config    | i_cfg_we, i_cfg_addr, i_cfg_wdata            | in
//
//  one request at a time; o_ready is high only while idle, the result
//  register lets the next request in while the last result waits
//  allocate: each scanned grid row passes read, count, fit and encode, then
//  each marked row gets a read-modify-write on the single row memory
//  free: a read-modify-write per cleared row; a rejected request goes from start straight to done
//  reset: synchronous; per-row valid flags clear the bitmap at once, no sweep
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_first_fit_rect_allocator
    import gffra_pkg::*;
#(
    parameter int GRID_COLS = DEF_GRID_COLS,
    parameter int GRID_ROWS = DEF_GRID_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request beat
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_func,
    input  logic [FIELD_W-1:0] i_rect_width,
    input  logic [FIELD_W-1:0] i_rect_height,
    input  logic [COORD_W-1:0] i_anchor_col,
    input  logic [COORD_W-1:0] i_anchor_row,
    // result beat
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_placed,
    output logic [COORD_W-1:0] o_found_col,
    output logic [COORD_W-1:0] o_found_row,
    // register writes
    input  logic               i_cfg_we,
    input  logic               i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata
);

    localparam int CI_W = idx_w(GRID_COLS);
    localparam int RI_W = idx_w(GRID_ROWS);
    localparam logic [DIM_W-1:0] COLS_MAX = DIM_W'(GRID_COLS);
    localparam logic [DIM_W-1:0] ROWS_MAX = DIM_W'(GRID_ROWS);
    localparam logic [DIM_W-1:0] ONE      = DIM_W'(1);

    // control state
    t_state r_state, n_state;
    logic [CFG_W-1:0] r_cols_cfg, r_rows_cfg;
    logic r_out_valid;

    // request held for the duration of the work
    logic             r_func;
    logic [DIM_W-1:0] r_w, r_h, r_ac, r_ar;

    // work registers
    logic [DIM_W-1:0]     r_row;    // row being scanned or rewritten
    logic [DIM_W-1:0]     r_rend;   // end (exclusive) of rows to rewrite
    logic [DIM_W-1:0]     r_lo, r_hi; // column span to set or clear
    logic                 r_placed;
    logic [COORD_W-1:0]   r_fcol, r_frow;
    logic [DIM_W-1:0]     r_vcnt [GRID_COLS]; // free run length down each column
    logic [GRID_COLS-1:0] r_ok;

    // result register
    logic               r_o_placed;
    logic [COORD_W-1:0] r_o_col, r_o_row;

    // combinational
    logic [DIM_W-1:0]     w_eff_cols, w_eff_rows;
    logic [DIM_W-1:0]     w_cols_ext, w_rows_ext;
    logic                 w_alloc_ok, w_free_ok;
    logic [DIM_W-1:0]     w_free_cend, w_free_rend;
    logic                 w_scan_last, w_rmw_last;
    logic [GRID_COLS-1:0] w_rd_data, w_wr_data, w_mask, w_ok;
    logic [DIM_W-1:0]     w_cnt [GRID_COLS];
    logic                 w_hit;
    logic [CI_W-1:0]      w_hit_col;
    logic [DIM_W-1:0]     w_hit_x, w_hit_y;
    logic                 w_rd_en, w_wr_en, w_fit_load, w_out_load;

    // grid in use, clamped to the built size
    assign w_cols_ext = DIM_W'(r_cols_cfg);
    assign w_rows_ext = DIM_W'(r_rows_cfg);
    assign w_eff_cols = (w_cols_ext > COLS_MAX) ? COLS_MAX : w_cols_ext;
    assign w_eff_rows = (w_rows_ext > ROWS_MAX) ? ROWS_MAX : w_rows_ext;

    assign w_alloc_ok = (r_w != '0) && (r_h != '0) && (r_w <= w_eff_cols)
                        && (r_h <= w_eff_rows);
    assign w_free_ok  = (r_w != '0) && (r_h != '0) && (r_ac < w_eff_cols)
                        && (r_ar < w_eff_rows);

    // free clips to the grid in use
    assign w_free_cend = ((r_ac + r_w) > w_eff_cols) ? w_eff_cols : (r_ac + r_w);
    assign w_free_rend = ((r_ar + r_h) > w_eff_rows) ? w_eff_rows : (r_ar + r_h);

    assign w_scan_last = ((r_row + ONE) >= w_eff_rows);
    assign w_rmw_last  = ((r_row + ONE) >= r_rend);

    // vertical run counts: a column is a usable anchor column for the candidate
    // row (current row - height + 1) once it has height free cells in a row
    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            if (w_rd_data[c]) begin
                w_cnt[c] = '0;
            end else if (r_vcnt[c] >= r_h) begin
                w_cnt[c] = r_h;
            end else begin
                w_cnt[c] = r_vcnt[c] + ONE;
            end
            w_ok[c] = (w_cnt[c] >= r_h) && (DIM_W'(c) < w_eff_cols);
        end
    end

    assign w_hit_x = DIM_W'(w_hit_col);
    assign w_hit_y = r_row - r_h + ONE;

    // cells touched by the current rewrite
    always_comb begin
        for (int c = 0; c < GRID_COLS; c++) begin
            w_mask[c] = (DIM_W'(c) >= r_lo) && (DIM_W'(c) < r_hi);
        end
    end

    assign w_wr_data = (r_func == FUNC_FREE) ? (w_rd_data & ~w_mask)
                                             : (w_rd_data | w_mask);

    gffra_mem #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS),
        .RI_W      (RI_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_row[RI_W-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_row[RI_W-1:0]),
        .i_wr_data (w_wr_data)
    );

    gffra_fit #(
        .GRID_COLS (GRID_COLS),
        .CI_W      (CI_W)
    ) u_fit (
        .i_clk   (i_clk),
        .i_load  (w_fit_load),
        .i_ok    (r_ok),
        .i_width (r_w[FIELD_W-1:0]),
        .o_hit   (w_hit),
        .o_col   (w_hit_col)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_func == FUNC_FREE) begin
                    n_state = w_free_ok ? S_RMW_RD : S_DONE;
                end else begin
                    n_state = w_alloc_ok ? S_SCAN_RD : S_DONE;
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_CNT;
            S_SCAN_CNT: n_state = S_SCAN_FIT;
            S_SCAN_FIT: n_state = S_SCAN_ENC;
            S_SCAN_ENC: begin
                if (w_hit) begin
                    n_state = S_RMW_RD;
                end else if (w_scan_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_RMW_RD: n_state = S_RMW_WR;
            S_RMW_WR: n_state = w_rmw_last ? S_DONE : S_RMW_RD;
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready    = 1'b0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_fit_load = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE:     o_ready    = 1'b1;
            S_SCAN_RD:  w_rd_en    = 1'b1;
            S_SCAN_FIT: w_fit_load = 1'b1;
            S_RMW_RD:   w_rd_en    = 1'b1;
            S_RMW_WR:   w_wr_en    = 1'b1;
            S_DONE:     w_out_load = !r_out_valid || i_ready;
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cols_cfg  <= COLS_RST;
            r_rows_cfg  <= ROWS_RST;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_addr))
                    CFG_COLS: r_cols_cfg <= i_cfg_wdata;
                    CFG_ROWS: r_rows_cfg <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_func <= i_func;
                    r_w    <= DIM_W'(i_rect_width);
                    r_h    <= DIM_W'(i_rect_height);
                    r_ac   <= DIM_W'(i_anchor_col);
                    r_ar   <= DIM_W'(i_anchor_row);
                end
            end
            S_START: begin
                // free always answers placed; allocate only on a hit
                r_placed <= (r_func == FUNC_FREE);
                r_fcol   <= '0;
                r_frow   <= '0;
                r_row    <= (r_func == FUNC_FREE) ? r_ar : '0;
                r_rend   <= w_free_rend;
                r_lo     <= r_ac;
                r_hi     <= w_free_cend;
                for (int c = 0; c < GRID_COLS; c++) begin
                    r_vcnt[c] <= '0;
                end
            end
            S_SCAN_CNT: begin
                for (int c = 0; c < GRID_COLS; c++) begin
                    r_vcnt[c] <= w_cnt[c];
                end
                r_ok <= w_ok;
            end
            S_SCAN_ENC: begin
                if (w_hit) begin
                    r_placed <= 1'b1;
                    r_fcol   <= COORD_W'(w_hit_col);
                    r_frow   <= COORD_W'(w_hit_y);
                    r_row    <= w_hit_y;
                    r_rend   <= r_row + ONE;
                    r_lo     <= w_hit_x;
                    r_hi     <= w_hit_x + r_w;
                end else begin
                    r_row <= r_row + ONE;
                end
            end
            S_RMW_WR: begin
                r_row <= r_row + ONE;
            end
            default: begin
            end
        endcase
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_placed <= r_placed;
            r_o_col    <= r_fcol;
            r_o_row    <= r_frow;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_placed    = r_o_placed;
    assign o_found_col = r_o_col;
    assign o_found_row = r_o_row;

    `ASSERT_CLK(a_scan_in_grid, i_clk, i_rst_n, (r_state == S_SCAN_RD) |-> (r_row < w_eff_rows))
    `ASSERT_CLK(a_rmw_in_grid, i_clk, i_rst_n, (r_state == S_RMW_WR) |-> ((r_row < w_eff_rows) && (r_row < r_rend)))
    `ASSERT_CLK(a_hit_fits, i_clk, i_rst_n, ((r_state == S_SCAN_ENC) && w_hit) |-> ((w_hit_x + r_w) <= w_eff_cols))
    `ASSERT_CLK(a_accept_starts, i_clk, i_rst_n, (i_valid && o_ready) |=> (r_state == S_START))

endmodule

// ----- dv/grid_first_fit_rect_allocator_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_first_fit_rect_allocator_tb
// drives allocate and free beats into the rectangle allocator, keeps its own
// occupancy bitmap to work out each expected placement, and checks every
// result beat in order; directed corner cases first, then random traffic
// over a series of grid sizes
// ---------------------------------------------------------------------------
module grid_first_fit_rect_allocator_tb;
    import gffra_pkg::*;

    localparam int NCOLS = DEF_GRID_COLS;
    localparam int NROWS = DEF_GRID_ROWS;

    typedef struct packed {
        logic               func;
        logic [FIELD_W-1:0] width;
        logic [FIELD_W-1:0] height;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_request;

    typedef struct packed {
        logic               placed;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_grant;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               i_func        = FUNC_ALLOC;
    logic [FIELD_W-1:0] i_rect_width  = '0;
    logic [FIELD_W-1:0] i_rect_height = '0;
    logic [COORD_W-1:0] i_anchor_col  = '0;
    logic [COORD_W-1:0] i_anchor_row  = '0;
    logic               i_ready       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_addr    = CFG_COLS;
    logic [CFG_W-1:0]   i_cfg_wdata   = '0;
    logic               o_ready;
    logic               o_valid;
    logic               o_placed;
    logic [COORD_W-1:0] o_found_col;
    logic [COORD_W-1:0] o_found_row;

    // shadow bitmap and grid size registers
    logic [NCOLS-1:0] occ_rows [NROWS];
    logic [CFG_W-1:0] cols_cfg;
    logic [CFG_W-1:0] rows_cfg;

    t_grant   grants_due [$];
    t_request live_rects [$];
    int       mismatch_count = 0;
    bit       steady         = 1'b0;
    int       stall_left     = 0;

    grid_first_fit_rect_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_anchor_col  (i_anchor_col),
        .i_anchor_row  (i_anchor_row),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_placed      (o_placed),
        .o_found_col   (o_found_col),
        .o_found_row   (o_found_row),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // grid size in use, clamped to the built grid
    function automatic int used_cols();
        return (int'(cols_cfg) > NCOLS) ? NCOLS : int'(cols_cfg);
    endfunction

    function automatic int used_rows();
        return (int'(rows_cfg) > NROWS) ? NROWS : int'(rows_cfg);
    endfunction

    function automatic logic [NCOLS-1:0] cell_span(input int first, input int count);
        logic [31:0] m;
        m = ((32'd1 << count) - 32'd1) << first;
        return m[NCOLS-1:0];
    endfunction

    // first-fit placement or rectangle clear on the shadow bitmap
    function automatic t_grant apply_request(input t_request rq);
        t_grant           g;
        int               cols;
        int               rows;
        int               w;
        int               h;
        int               ac;
        int               ar;
        int               cend;
        int               rend;
        logic [NCOLS-1:0] span;
        bit               clash;
        bit               found;
        g     = '0;
        cols  = used_cols();
        rows  = used_rows();
        w     = int'(rq.width);
        h     = int'(rq.height);
        ac    = int'(rq.col);
        ar    = int'(rq.row);
        found = 1'b0;
        if (rq.func == FUNC_FREE) begin
            // only the part inside the grid in use is cleared
            if (w != 0 && h != 0 && ac < cols && ar < rows) begin
                cend = (ac + w > cols) ? cols : ac + w;
                rend = (ar + h > rows) ? rows : ar + h;
                span = cell_span(ac, cend - ac);
                for (int r = ar; r < rend; r++)
                    occ_rows[r] &= ~span;
            end
            g.placed = 1'b1;
            return g;
        end
        if (w == 0 || h == 0 || w > cols || h > rows)
            return g;
        for (int y = 0; y + h <= rows && !found; y++) begin
            for (int x = 0; x + w <= cols && !found; x++) begin
                span  = cell_span(x, w);
                clash = 1'b0;
                for (int r = y; r < y + h; r++)
                    if ((occ_rows[r] & span) != '0)
                        clash = 1'b1;
                if (!clash) begin
                    for (int r = y; r < y + h; r++)
                        occ_rows[r] |= span;
                    g.placed = 1'b1;
                    g.col    = x[COORD_W-1:0];
                    g.row    = y[COORD_W-1:0];
                    found    = 1'b1;
                end
            end
        end
        return g;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // one request beat; valid is left high on return so a follow-on beat
    // can go out at the very next edge
    task automatic request(input logic func, input int w, input int h,
                           input int c, input int r);
        t_request rq;
        t_grant   g;
        int       gap;
        rq.func   = func;
        rq.width  = w[FIELD_W-1:0];
        rq.height = h[FIELD_W-1:0];
        rq.col    = c[COORD_W-1:0];
        rq.row    = r[COORD_W-1:0];
        gap       = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= rq.func;
        i_rect_width  <= rq.width;
        i_rect_height <= rq.height;
        i_anchor_col  <= rq.col;
        i_anchor_row  <= rq.row;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        g = apply_request(rq);
        grants_due.insert(grants_due.size(), g);
        // remember placements so random traffic can free them again
        if (func == FUNC_ALLOC && g.placed)
            live_rects.insert(live_rects.size(),
                              t_request'{FUNC_FREE, rq.width, rq.height, g.col, g.row});
    endtask

    // drop valid and wait until every result beat has come back
    task automatic settle();
        i_valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // new grid size, written only while the block is idle
    task automatic reconfigure(input int ncols, input int nrows);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_COLS;
        i_cfg_wdata <= ncols[CFG_W-1:0];
        @(posedge i_clk);
        cols_cfg     = ncols[CFG_W-1:0];
        i_cfg_addr  <= CFG_ROWS;
        i_cfg_wdata <= nrows[CFG_W-1:0];
        @(posedge i_clk);
        rows_cfg     = nrows[CFG_W-1:0];
        i_cfg_we    <= 1'b0;
    endtask

    // reset grid size: first fit, too wide, zero sizes, free and refit
    task automatic test_default_grid();
        request(FUNC_ALLOC, 1, 1, 0, 0);
        request(FUNC_ALLOC, 10, 1, 15, 15);
        request(FUNC_ALLOC, 11, 1, 0, 0);
        request(FUNC_ALLOC, 0, 3, 0, 0);
        request(FUNC_ALLOC, 2, 0, 0, 0);
        request(FUNC_FREE, 0, 4, 0, 0);
        request(FUNC_FREE, 1, 1, 0, 0);
        request(FUNC_ALLOC, 3, 2, 0, 0);
    endtask

    // whole grid: fill it, free a corner past the edge, oversized rects
    task automatic test_full_grid();
        reconfigure(NCOLS, NROWS);
        request(FUNC_FREE, 31, 31, 0, 0);
        request(FUNC_ALLOC, 16, 16, 0, 0);
        request(FUNC_ALLOC, 1, 1, 0, 0);
        request(FUNC_FREE, 31, 31, 15, 15);
        request(FUNC_ALLOC, 1, 1, 0, 0);
        request(FUNC_ALLOC, 17, 1, 0, 0);
        request(FUNC_FREE, 16, 16, 0, 0);
        request(FUNC_ALLOC, 16, 1, 0, 0);
        request(FUNC_ALLOC, 1, 16, 0, 0);
    endtask

    // empty grid, single cell, sizes above the grid, shrink then grow
    task automatic test_grid_bounds();
        reconfigure(0, 0);
        request(FUNC_ALLOC, 1, 1, 0, 0);
        request(FUNC_FREE, 16, 16, 0, 0);
        reconfigure(1, 1);
        request(FUNC_ALLOC, 1, 1, 0, 0);
        request(FUNC_FREE, 1, 1, 1, 0);
        request(FUNC_FREE, 2, 2, 0, 0);
        request(FUNC_ALLOC, 1, 1, 0, 0);
        reconfigure(31, 31);
        request(FUNC_ALLOC, 16, 1, 0, 0);
        // cells outside a shrunk grid must survive a full clear
        reconfigure(4, 4);
        request(FUNC_FREE, 31, 31, 0, 0);
        request(FUNC_ALLOC, 4, 4, 0, 0);
        reconfigure(NCOLS, NROWS);
        request(FUNC_ALLOC, 12, 1, 0, 0);
    endtask

    // one random beat: mostly fits and frees of live rects, some noise
    task automatic random_item();
        int       cols;
        int       rows;
        int       roll;
        int       k;
        int       w;
        int       h;
        t_request rq;
        cols = (used_cols() < 1) ? 1 : used_cols();
        rows = (used_rows() < 1) ? 1 : used_rows();
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            if ($urandom_range(0, 3) == 0) begin
                w = $urandom_range(1, cols);
                h = $urandom_range(1, rows);
            end else begin
                w = $urandom_range(1, (cols < 4) ? cols : 4);
                h = $urandom_range(1, (rows < 4) ? rows : 4);
            end
            request(FUNC_ALLOC, w, h, $urandom_range(0, 15), $urandom_range(0, 15));
        end else if (roll < 60) begin
            request(FUNC_ALLOC, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 15), $urandom_range(0, 15));
        end else if (roll < 88 && live_rects.size() > 0) begin
            k  = $urandom_range(0, live_rects.size() - 1);
            rq = live_rects[k];
            live_rects.delete(k);
            request(FUNC_FREE, rq.width, rq.height, rq.col, rq.row);
        end else if (roll < 90) begin
            request(FUNC_FREE, 31, 31, 0, 0);
            live_rects.delete();
        end else begin
            request(FUNC_FREE, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 15), $urandom_range(0, 15));
        end
    endtask

    // phases of random traffic, each with its own grid size
    task automatic test_random_traffic();
        int ncols;
        int nrows;
        int count;
        for (int phase = 0; phase < 12; phase++) begin
            ncols = $urandom_range(2, NCOLS);
            nrows = $urandom_range(2, NROWS);
            case (phase)
                0: begin ncols = NCOLS; nrows = NROWS; end
                1: begin ncols = 31;    nrows = 31;    end
                2: begin ncols = 1;     nrows = NROWS; end
                3: begin ncols = NCOLS; nrows = 1;     end
                4: ncols = 0;
                5: nrows = 0;
                6: ncols = $urandom_range(NCOLS + 1, 31);
                default: ;
            endcase
            steady = (phase == 7) || ($urandom_range(0, 3) == 0);
            reconfigure(ncols, nrows);
            count = (ncols == 0 || nrows == 0) ? 15 : 55;
            for (int n = 0; n < count; n++)
                random_item();
        end
        steady = 1'b0;
    endtask

    // result side: random stalls on i_ready, in-order compare on each beat
    always @(posedge i_clk) begin : result_check
        t_grant want;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: unexpected result beat placed=%0b col=%0d row=%0d",
                             $time, o_placed, o_found_col, o_found_row);
                    mismatch_count++;
                end else begin
                    want = grants_due.pop_front();
                    if ({o_placed, o_found_col, o_found_row} !== want) begin
                        $display("%0t: expected placed=%0b col=%0d row=%0d, got placed=%0b col=%0d row=%0d",
                                 $time, want.placed, want.col, want.row,
                                 o_placed, o_found_col, o_found_row);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready   <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        foreach (occ_rows[r])
            occ_rows[r] = '0;
        cols_cfg = COLS_RST;
        rows_cfg = ROWS_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_grid();
        test_full_grid();
        test_grid_bounds();
        test_random_traffic();

        settle();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
